// ----- hw/rtl/photon256_linear_layer_assert.svh -----
// Assertion macros for the PHOTON-256 linear layer.
// Both expect signals named clk and rst in the scope of use.
`ifndef PHOTON256_LINEAR_LAYER_ASSERT_SVH
`define PHOTON256_LINEAR_LAYER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define P256LL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("photon256_linear_layer: assertion failed");

// Checked on every edge, reset included.
`define P256LL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("photon256_linear_layer: reset assertion failed");

`else

`define P256LL_ASSERT(lbl, prop)
`define P256LL_ASSERT_RST(lbl, prop)

`endif

`endif

// ----- hw/rtl/p256ll_pkg.sv -----
`timescale 1ns / 1ps

package p256ll_pkg;

  localparam int CELLS = 8;

  typedef logic [3:0] gf_t;
  typedef gf_t [CELLS-1:0] row_t;   // cell j at bits 4j+3..4j
  typedef row_t [CELLS-1:0] state_t; // [row][col]
  typedef gf_t [CELLS-1:0] col_t;   // [row]

  // x^4 + x + 1, low terms
  localparam gf_t RED_POLY = 4'h3;

  typedef enum logic {
    KIND_FWD = 1'b0,
    KIND_INV = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] row_in_0;
    logic [31:0] row_in_1;
    logic [31:0] row_in_2;
    logic [31:0] row_in_3;
    logic [31:0] row_in_4;
    logic [31:0] row_in_5;
    logic [31:0] row_in_6;
    logic [31:0] row_in_7;
  } in_req_t;

  typedef struct packed {
    logic [31:0] row_out_0;
    logic [31:0] row_out_1;
    logic [31:0] row_out_2;
    logic [31:0] row_out_3;
    logic [31:0] row_out_4;
    logic [31:0] row_out_5;
    logic [31:0] row_out_6;
    logic [31:0] row_out_7;
  } out_res_t;

  localparam gf_t FWD_MAT [CELLS][CELLS] = '{
    '{4'd2,  4'd4,  4'd2,  4'd11, 4'd2,  4'd8,  4'd5,  4'd6},
    '{4'd12, 4'd9,  4'd8,  4'd13, 4'd7,  4'd7,  4'd5,  4'd2},
    '{4'd4,  4'd4,  4'd13, 4'd13, 4'd9,  4'd4,  4'd13, 4'd9},
    '{4'd1,  4'd6,  4'd5,  4'd1,  4'd12, 4'd13, 4'd15, 4'd14},
    '{4'd15, 4'd12, 4'd9,  4'd13, 4'd14, 4'd5,  4'd14, 4'd13},
    '{4'd9,  4'd14, 4'd5,  4'd15, 4'd4,  4'd12, 4'd9,  4'd6},
    '{4'd12, 4'd2,  4'd2,  4'd10, 4'd3,  4'd1,  4'd1,  4'd14},
    '{4'd15, 4'd1,  4'd13, 4'd10, 4'd5,  4'd10, 4'd2,  4'd3}
  };

  localparam gf_t INV_MAT [CELLS][CELLS] = '{
    '{4'd4,  4'd7,  4'd9,  4'd10, 4'd12, 4'd12, 4'd3,  4'd15},
    '{4'd13, 4'd13, 4'd10, 4'd10, 4'd7,  4'd13, 4'd10, 4'd7},
    '{4'd14, 4'd2,  4'd3,  4'd14, 4'd4,  4'd10, 4'd5,  4'd11},
    '{4'd5,  4'd4,  4'd7,  4'd10, 4'd11, 4'd3,  4'd11, 4'd10},
    '{4'd7,  4'd11, 4'd3,  4'd5,  4'd13, 4'd4,  4'd7,  4'd2},
    '{4'd4,  4'd15, 4'd15, 4'd6,  4'd1,  4'd14, 4'd14, 4'd11},
    '{4'd5,  4'd14, 4'd10, 4'd6,  4'd3,  4'd6,  4'd15, 4'd1},
    '{4'd2,  4'd1,  4'd12, 4'd1,  4'd4,  4'd11, 4'd3,  4'd9}
  };

  function automatic gf_t gf_mul(gf_t a, gf_t b);
    gf_t x;
    gf_t acc;
    x   = a;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = x[3] ? ({x[2:0], 1'b0} ^ RED_POLY) : {x[2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// ----- hw/rtl/p256ll_rot.sv -----
`timescale 1ns / 1ps

// Rotates row r by r cells; passes the state through when not active.
module p256ll_rot
  import p256ll_pkg::*;
(
  input  state_t st_in,
  input  logic   active,
  input  logic   to_left,
  output state_t st_out
);

  logic [2:0] src;

  always_comb begin
    src = '0;
    for (int r = 0; r < CELLS; r++) begin
      for (int j = 0; j < CELLS; j++) begin
        // left: new cell j takes old cell j+r; right: old cell j-r
        src = to_left ? 3'(j + r) : 3'(j - r);
        st_out[r][j] = active ? st_in[r][src] : st_in[r][j];
      end
    end
  end

endmodule

// ----- hw/rtl/p256ll_mix.sv -----
`timescale 1ns / 1ps

// One column times the MixColumnSerial matrix (or its inverse) over GF(16).
module p256ll_mix
  import p256ll_pkg::*;
(
  input  col_t col_in,
  input  logic inv,
  output col_t col_out
);

  gf_t acc;

  always_comb begin
    acc = '0;
    for (int r = 0; r < CELLS; r++) begin
      acc = '0;
      for (int k = 0; k < CELLS; k++) begin
        acc ^= gf_mul(inv ? INV_MAT[r][k] : FWD_MAT[r][k], col_in[k]);
      end
      col_out[r] = acc;
    end
  end

endmodule

// ----- hw/rtl/photon256_linear_layer.sv -----
`timescale 1ns / 1ps

// PHOTON-256 linear layer: ShiftRows + MixColumnSerial, or the inverse.
//
// in_valid/in_ready carry one request: kind plus eight 32-bit state rows.
// out_valid/out_ready carry the transformed eight rows. No state is kept
// between requests.
//
// The request is captured in an input register; rotation, the GF(16)
// column mix and the inverse rotation all sit between that register and
// the output register; out_valid rises when the result is loaded there.
// Two-register pipeline: one request per cycle while out_ready is high.
//
// Reset clears both valid flags; nothing else needs clearing.
// When the receiver holds out_ready low the result stays in the output
// register and one more request can wait in the input register; in_ready
// then drops until the output register drains.
module photon256_linear_layer
  import p256ll_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

`include "photon256_linear_layer_assert.svh"

  logic     s1_valid;
  in_req_t  s1_q;
  logic     adv;
  logic     is_inv;
  state_t   st_in;
  state_t   st_shift;
  state_t   st_mixed;
  state_t   st_res;
  col_t     mix_in  [CELLS];
  col_t     mix_out [CELLS];

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_q <= in_data;
    if (adv && s1_valid) begin
      out_data.row_out_0 <= st_res[0];
      out_data.row_out_1 <= st_res[1];
      out_data.row_out_2 <= st_res[2];
      out_data.row_out_3 <= st_res[3];
      out_data.row_out_4 <= st_res[4];
      out_data.row_out_5 <= st_res[5];
      out_data.row_out_6 <= st_res[6];
      out_data.row_out_7 <= st_res[7];
    end
  end

  assign is_inv = (s1_q.kind == KIND_INV);

  assign st_in[0] = s1_q.row_in_0;
  assign st_in[1] = s1_q.row_in_1;
  assign st_in[2] = s1_q.row_in_2;
  assign st_in[3] = s1_q.row_in_3;
  assign st_in[4] = s1_q.row_in_4;
  assign st_in[5] = s1_q.row_in_5;
  assign st_in[6] = s1_q.row_in_6;
  assign st_in[7] = s1_q.row_in_7;

  // forward: rotate left before the mix
  p256ll_rot u_rot_pre (
    .st_in  (st_in),
    .active (!is_inv),
    .to_left(1'b1),
    .st_out (st_shift)
  );

  always_comb begin
    for (int c = 0; c < CELLS; c++) begin
      for (int r = 0; r < CELLS; r++) begin
        mix_in[c][r]    = st_shift[r][c];
        st_mixed[r][c]  = mix_out[c][r];
      end
    end
  end

  for (genvar c = 0; c < CELLS; c++) begin : g_col
    p256ll_mix u_mix (
      .col_in (mix_in[c]),
      .inv    (is_inv),
      .col_out(mix_out[c])
    );
  end

  // inverse: rotate right after the mix
  p256ll_rot u_rot_post (
    .st_in  (st_mixed),
    .active (is_inv),
    .to_left(1'b0),
    .st_out (st_res)
  );

  `P256LL_ASSERT_RST(a_reset_clears, rst |=> (!out_valid && !s1_valid))
  `P256LL_ASSERT(a_accept_fills, (in_valid && in_ready) |=> s1_valid)
  `P256LL_ASSERT(a_advance_shows, (s1_valid && adv) |=> out_valid)
  `P256LL_ASSERT(a_stall_holds, (s1_valid && !adv) |=> (s1_valid && $stable(s1_q)))

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import p256ll_pkg::*;

  typedef logic [0:7][31:0] rows_t;  // rows_t[0] lines up with row 0 of a request

  typedef struct {
    in_req_t req;
    bit      drain;  // hold this request until every result is back
  } pend_t;

  localparam gf_t POLY_LOW = 4'h3;

  localparam gf_t MIX_FWD [8][8] = '{
    '{2,  4,  2, 11,  2,  8,  5,  6},
    '{12, 9,  8, 13,  7,  7,  5,  2},
    '{4,  4, 13, 13,  9,  4, 13,  9},
    '{1,  6,  5,  1, 12, 13, 15, 14},
    '{15, 12, 9, 13, 14,  5, 14, 13},
    '{9, 14,  5, 15,  4, 12,  9,  6},
    '{12, 2,  2, 10,  3,  1,  1, 14},
    '{15, 1, 13, 10,  5, 10,  2,  3}
  };

  localparam gf_t MIX_INV [8][8] = '{
    '{4,  7,  9, 10, 12, 12,  3, 15},
    '{13, 13, 10, 10, 7, 13, 10,  7},
    '{14, 2,  3, 14,  4, 10,  5, 11},
    '{5,  4,  7, 10, 11,  3, 11, 10},
    '{7, 11,  3,  5, 13,  4,  7,  2},
    '{4, 15, 15,  6,  1, 14, 14, 11},
    '{5, 14, 10,  6,  3,  6, 15,  1},
    '{2,  1, 12,  1,  4, 11,  3,  9}
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  pend_t    state_reqs_q [$];
  out_res_t layer_results_q [$];
  logic     in_taken = 1'b0;
  int       got_cnt = 0;
  int       fail_cnt = 0;
  int       hold_cnt = 0;
  bit       held = 1'b0;

  photon256_linear_layer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic gf_t gf16_times(gf_t a, gf_t b);
    gf_t sh;
    gf_t prod;
    sh   = a;
    prod = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) prod ^= sh;
      sh = {sh[2:0], 1'b0} ^ (sh[3] ? POLY_LOW : 4'h0);
    end
    return prod;
  endfunction

  // forward: rotate row r left by r, then mix columns; inverse: mix, then rotate right
  function automatic out_res_t predict_layer(in_req_t req);
    rows_t rows;
    rows_t res;
    gf_t   pre [8][8];
    gf_t   mixed [8][8];
    gf_t   acc;
    bit    inv;
    inv  = (req.kind == KIND_INV);
    rows = req[255:0];
    for (int r = 0; r < 8; r++)
      for (int j = 0; j < 8; j++)
        pre[r][j] = inv ? rows[r][4*j +: 4] : rows[r][4*((j + r) % 8) +: 4];
    for (int c = 0; c < 8; c++)
      for (int r = 0; r < 8; r++) begin
        acc = '0;
        for (int k = 0; k < 8; k++)
          acc ^= gf16_times(inv ? MIX_INV[r][k] : MIX_FWD[r][k], pre[k][c]);
        mixed[r][c] = acc;
      end
    for (int r = 0; r < 8; r++)
      for (int j = 0; j < 8; j++)
        res[r][4*j +: 4] = inv ? mixed[r][(j + 8 - r) % 8] : mixed[r][j];
    return res;
  endfunction

  task automatic add_req(input kind_t k, input rows_t rows, input bit drain);
    pend_t p;
    p.req   = {k, rows};
    p.drain = drain;
    state_reqs_q.push_back(p);
  endtask

  function automatic rows_t rand_rows();
    rows_t rows;
    for (int r = 0; r < 8; r++) rows[r] = $urandom();
    return rows;
  endfunction

  // stimulus, then end-of-run bookkeeping
  initial begin
    rows_t rows;
    kind_t k;
    int    mode;
    int    nz;
    bit    mid_drain;
    mid_drain = 1'b0;

    add_req(KIND_FWD, '0, 1'b0);
    add_req(KIND_INV, '0, 1'b0);
    add_req(KIND_FWD, '1, 1'b0);
    add_req(KIND_INV, '1, 1'b0);
    add_req(KIND_FWD, {8{32'hAAAAAAAA}}, 1'b0);
    add_req(KIND_INV, {8{32'hAAAAAAAA}}, 1'b0);
    add_req(KIND_FWD, {8{32'h55555555}}, 1'b0);
    add_req(KIND_INV, {8{32'h55555555}}, 1'b0);
    // a single lit cell in row r shows where each rotation lands
    for (int r = 0; r < 8; r++) begin
      rows = '0;
      rows[r][4*((3*r) % 8) +: 4] = 4'h9;
      add_req(KIND_FWD, rows, 1'b0);
      add_req(KIND_INV, rows, 1'b0);
    end

    while (state_reqs_q.size() < 1950) begin
      mode = $urandom_range(0, 9);
      k    = kind_t'($urandom_range(0, 1));
      if (mode == 0) begin
        rows = '0;
        nz = $urandom_range(1, 8);
        for (int i = 0; i < nz; i++)
          rows[$urandom_range(0, 7)][4*$urandom_range(0, 7) +: 4] =
            4'($urandom_range(1, 15));
      end else begin
        rows = rand_rows();
      end
      if (mode <= 2) begin
        // forward then inverse of its result must give the state back
        add_req(KIND_FWD, rows, state_reqs_q.size() == 24);
        rows = predict_layer({KIND_FWD, rows});
        add_req(KIND_INV, rows, 1'b0);
      end else begin
        add_req(k, rows, state_reqs_q.size() == 24 ||
                (!mid_drain && state_reqs_q.size() >= 1200));
        if (state_reqs_q.size() > 1200) mid_drain = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (state_reqs_q.size() != 0 || in_valid);
    while (layer_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && layer_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (state_reqs_q.size() == 0 ||
          (state_reqs_q[0].drain && layer_results_q.size() != 0) ||
          (!(state_reqs_q.size() inside {[700:1000]}) && $urandom_range(0, 99) < 13)) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= state_reqs_q[0].req;
        in_valid <= 1'b1;
        void'(state_reqs_q.pop_front());
      end
    end
  end

  // result receiver; one long hold-off lets the pipe fill and back up
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (got_cnt >= 300 && !held) begin
      out_ready <= 1'b0;
      hold_cnt  <= 200;
      held      <= 1'b1;
    end else if (got_cnt inside {[1000:1300]}) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 13);
    end
  end

  // monitor: check results, then log newly accepted requests
  always @(posedge clk) begin
    rows_t want;
    rows_t seen;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_cnt <= got_cnt + 1;
        if (layer_results_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_data);
          fail_cnt++;
        end else begin
          want = layer_results_q.pop_front();
          seen = out_data;
          for (int r = 0; r < 8; r++)
            if (seen[r] !== want[r]) begin
              $error("row_out_%0d: expected %h, got %h", r, want[r], seen[r]);
              fail_cnt++;
            end
        end
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) layer_results_q.push_back(predict_layer(in_data));
    end
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/p256ll_pkg.sv
hw/rtl/p256ll_rot.sv
hw/rtl/p256ll_mix.sv
hw/rtl/photon256_linear_layer.sv
verif/testbench.sv
